// ===== rtl/qrda_pkg.sv =====
// shared types, constants and helpers for the quad region depth average block
package qrda_pkg;

	localparam int CORNER_COUNT_DEF  = 4;
	localparam int MAX_COLUMNS_DEF   = 1024;
	localparam int MAX_ROWS_DEF      = 1024;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int CW = 13;  // corner coordinate width
	localparam int PW = 10;  // pixel coordinate width
	localparam int NW = 21;  // count width
	localparam int SW = 53;  // sum width
	localparam int QD = 4;   // queue depth
	localparam int QAW = 2;  // queue address width

	localparam logic [NW-1:0] COUNT_LIMIT = 21'h1FFFFF;

	// register indexes
	typedef enum logic [2:0] {
		REG_C0_COL = 3'd0, REG_C0_ROW = 3'd1, REG_C1_COL = 3'd2, REG_C1_ROW = 3'd3,
		REG_C2_COL = 3'd4, REG_C2_ROW = 3'd5, REG_C3_COL = 3'd6, REG_C3_ROW = 3'd7
	} reg_idx_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        take;
		logic        last;
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fz;
	} qitem_t;

	typedef enum logic [1:0] {
		BK_ACC, BK_DIV, BK_OUT
	} bk_state_t;

	function automatic logic float_bad(input logic [31:0] f);
		return f[30:23] == 8'hFF;
	endfunction

	function automatic logic float_zero(input logic [31:0] f);
		return f[30:0] == 31'd0;
	endfunction

	// float to signed fixed, truncate toward zero, saturate to 32 bits
	function automatic logic signed [32:0] float_to_fix(input logic [31:0] f,
			input int fb);
		logic [23:0]  sig;
		int           k;
		logic [32:0]  mag;
		logic [55:0]  wide;
		sig = (f[30:23] == 8'd0) ? {1'b0, f[22:0]} : {1'b1, f[22:0]};
		k = (f[30:23] == 8'd0) ? (-149 + fb) : (int'(f[30:23]) - 150 + fb);
		if (k > 8) begin
			mag = 33'h080000000;
		end else if (k >= 0) begin
			wide = 56'(sig) << k;
			mag = wide[32:0];
		end else if (k > -32) begin
			wide = 56'(sig) >> (-k);
			mag = wide[32:0];
		end else begin
			mag = 33'd0;
		end
		if (f[31]) begin
			if (mag > 33'h080000000) mag = 33'h080000000;
			return -$signed(mag);
		end else begin
			if (mag > 33'h07FFFFFFF) mag = 33'h07FFFFFFF;
			return $signed(mag);
		end
	endfunction

endpackage

// ===== rtl/qrda_front.sv =====
// front end: pipelined polygon test over each edge of the quad, point classification
module qrda_front import qrda_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 advance,
	input  logic signed [CW-1:0] ccol [4],
	input  logic signed [CW-1:0] crow [4],
	input  logic [PW-1:0]        pixel_col,
	input  logic [PW-1:0]        pixel_row,
	input  logic [31:0]          x_bits,
	input  logic [31:0]          y_bits,
	input  logic [31:0]          z_bits,
	input  logic                 last_pixel,
	output logic                 out_valid,
	output qitem_t               out_item
);
	// stage 1: per edge numerator and denominator
	logic                 v_s1, v_s2, v_s3;
	logic                 ok_s1, ok_s2;
	logic [PW-1:0]        col_s1;
	logic [31:0]          fx_s1, fy_s1, fz_s1, fx_s2, fy_s2, fz_s2;
	logic                 last_s1, last_s2;
	logic                 span_s1 [4];
	logic signed [27:0]   num_s1 [4];
	logic signed [14:0]   den_s1 [4];
	logic signed [CW-1:0] xa_s1 [4];
	logic                 hit_s2 [4];
	qitem_t               item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			col_s1  <= pixel_col;
			fx_s1   <= x_bits;
			fy_s1   <= y_bits;
			fz_s1   <= z_bits;
			last_s1 <= last_pixel;
			ok_s1   <= (32'(pixel_col) < MAX_COLUMNS) && (32'(pixel_row) < MAX_ROWS);
			for (int a = 0; a < 4; a++) begin
				logic signed [14:0] py, ya, yb, xa, xb;
				py = $signed({5'd0, pixel_row});
				ya = 15'(crow[a]);
				yb = 15'(crow[(a + 3) % 4]);
				xa = 15'(ccol[a]);
				xb = 15'(ccol[(a + 3) % 4]);
				span_s1[a] <= (ya > py) != (yb > py);
				num_s1[a]  <= 28'(xb - xa) * 28'(py - ya);
				den_s1[a]  <= yb - ya;
				xa_s1[a]   <= ccol[a];
			end
			// stage 2: column against the truncated crossing, by multiplication
			// with the edge height made positive
			fx_s2   <= fx_s1;
			fy_s2   <= fy_s1;
			fz_s2   <= fz_s1;
			last_s2 <= last_s1;
			ok_s2   <= ok_s1;
			for (int a = 0; a < 4; a++) begin
				logic signed [15:0] t0, dd;
				logic signed [29:0] nn, lhs;
				t0 = $signed({6'd0, col_s1}) - 16'(xa_s1[a]);
				dd = den_s1[a][14] ? -16'(den_s1[a]) : 16'(den_s1[a]);
				nn = den_s1[a][14] ? -30'(num_s1[a]) : 30'(num_s1[a]);
				// quotient at or above zero: t + 1 <= quotient, else t < quotient
				lhs = nn[29] ? 30'(t0) * 30'(dd) : (30'(t0) + 30'sd1) * 30'(dd);
				hit_s2[a] <= span_s1[a] && (nn[29] ? (lhs < nn) : (lhs <= nn));
			end
			// stage 3: crossing parity and point checks
			begin
				logic odd;
				odd = 1'b0;
				for (int a = 0; a < 4; a++)
					if (hit_s2[a]) odd = ~odd;
				item_s3.take <= ok_s2 && odd && !float_bad(fx_s2) && !float_bad(fy_s2) &&
					!float_bad(fz_s2) &&
					!(float_zero(fx_s2) && float_zero(fy_s2) && float_zero(fz_s2));
				item_s3.last <= last_s2;
				item_s3.fx   <= fx_s2;
				item_s3.fy   <= fy_s2;
				item_s3.fz   <= fz_s2;
			end
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;
endmodule

// ===== rtl/qrda_queue.sv =====
// short fifo between front and back
module qrda_queue import qrda_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qitem_t push_item,
	input  logic   pop,
	output logic   not_empty,
	output logic   room,
	output qitem_t head
);
	qitem_t         mem_q [QD];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	assign not_empty = cnt_q != '0;
	assign room      = cnt_q < (QAW+1)'(QD);
	assign head      = mem_q[rp_q];
endmodule

// ===== rtl/qrda_back.sv =====
// back end: conversion, accumulation, serial division of the sums
module qrda_back import qrda_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               has_item,
	input  qitem_t             item,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [NW-1:0]      points_found,
	output logic signed [31:0] mean_x,
	output logic signed [31:0] mean_y,
	output logic signed [31:0] mean_z,
	output logic               no_points
);
	bk_state_t state_q, state_nx;
	logic signed [SW-1:0] sx_q, sy_q, sz_q;
	logic [NW-1:0]        n_q;
	// restoring division of magnitudes, one bit per cycle for all three sums
	logic [SW-1:0]        qx_q, qy_q, qz_q;
	logic [NW:0]          rx_q, ry_q, rz_q;
	logic                 nx_q, ny_q, nz_q;
	logic [5:0]           bit_q;
	logic                 rv_q;
	logic                 do_acc, add_pt, start_div, div_done;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_ACC: if (has_item && item.last && !rv_q) state_nx = BK_DIV;
			BK_DIV: if (div_done) state_nx = BK_OUT;
			BK_OUT: state_nx = BK_ACC;
			default: state_nx = BK_ACC;
		endcase
	end

	always_comb begin
		do_acc    = 1'b0;
		start_div = 1'b0;
		case (state_q)
			BK_ACC: begin
				do_acc    = has_item && (!item.last || !rv_q);
				start_div = has_item && item.last && !rv_q;
			end
			default: ;
		endcase
	end
	assign pop      = do_acc;
	assign add_pt   = do_acc && item.take && (n_q < COUNT_LIMIT);
	assign div_done = bit_q == 6'd0;

	function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
		return v[SW-1] ? SW'(-v) : SW'(v);
	endfunction

	function automatic logic [NW:0] rstep(input logic [NW:0] r, input logic b,
			input logic [NW-1:0] d);
		logic [NW+1:0] t;
		t = {r, b};
		return (t >= (NW+2)'(d)) ? (NW+1)'(t - (NW+2)'(d)) : (NW+1)'(t);
	endfunction

	function automatic logic qbit(input logic [NW:0] r, input logic b,
			input logic [NW-1:0] d);
		return {r, b} >= (NW+2)'(d);
	endfunction

	logic signed [SW-1:0] ax, ay, az;
	assign ax = sx_q + SW'(float_to_fix(item.fx, FRACTION_BITS));
	assign ay = sy_q + SW'(float_to_fix(item.fy, FRACTION_BITS));
	assign az = sz_q + SW'(float_to_fix(item.fz, FRACTION_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_ACC;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
			n_q  <= '0;
			bit_q <= '0;
			rv_q <= 1'b0;
			qx_q <= '0; qy_q <= '0; qz_q <= '0;
			rx_q <= '0; ry_q <= '0; rz_q <= '0;
			nx_q <= 1'b0; ny_q <= 1'b0; nz_q <= 1'b0;
			points_found <= '0;
			no_points    <= 1'b0;
			mean_x <= '0; mean_y <= '0; mean_z <= '0;
		end else begin
			state_q <= state_nx;
			if (rv_q && !res_stall) rv_q <= 1'b0;
			if (add_pt) begin
				sx_q <= ax; sy_q <= ay; sz_q <= az;
				n_q  <= n_q + 1'b1;
			end
			if (start_div) begin
				bit_q <= 6'(SW);
				if (add_pt) begin
					qx_q <= mag(ax); qy_q <= mag(ay); qz_q <= mag(az);
					nx_q <= ax[SW-1]; ny_q <= ay[SW-1]; nz_q <= az[SW-1];
				end else begin
					qx_q <= mag(sx_q); qy_q <= mag(sy_q); qz_q <= mag(sz_q);
					nx_q <= sx_q[SW-1]; ny_q <= sy_q[SW-1]; nz_q <= sz_q[SW-1];
				end
				rx_q <= '0; ry_q <= '0; rz_q <= '0;
			end
			if (state_q == BK_DIV && !div_done) begin
				bit_q <= bit_q - 1'b1;
				rx_q <= rstep(rx_q, qx_q[SW-1], n_q);
				ry_q <= rstep(ry_q, qy_q[SW-1], n_q);
				rz_q <= rstep(rz_q, qz_q[SW-1], n_q);
				qx_q <= {qx_q[SW-2:0], qbit(rx_q, qx_q[SW-1], n_q)};
				qy_q <= {qy_q[SW-2:0], qbit(ry_q, qy_q[SW-1], n_q)};
				qz_q <= {qz_q[SW-2:0], qbit(rz_q, qz_q[SW-1], n_q)};
			end
			if (state_q == BK_OUT) begin
				rv_q         <= 1'b1;
				points_found <= n_q;
				no_points    <= n_q == '0;
				mean_x <= (n_q == '0) ? 32'sd0 : 32'(nx_q ? SW'(-qx_q) : qx_q);
				mean_y <= (n_q == '0) ? 32'sd0 : 32'(ny_q ? SW'(-qy_q) : qy_q);
				mean_z <= (n_q == '0) ? 32'sd0 : 32'(nz_q ? SW'(-qz_q) : qz_q);
				sx_q <= '0; sy_q <= '0; sz_q <= '0;
				n_q  <= '0;
			end
		end
	end

	assign res_valid = rv_q;
endmodule

// ===== rtl/quad_region_depth_average.sv =====
// top level of the quad region depth average block
// Counts the valid depth points of a frame that fall inside a four-corner
// polygon and reports their count and mean Q16.16 position on the last pixel.
// Pixels are taken at one per cycle through a three stage front end (edge
// products, edge compares, crossing parity) into a four entry queue; the back
// end sums one point per cycle. On the last pixel the back end runs a bit
// serial divider over the three sums in 53 steps, then leaves the divider and
// registers the result in its output state.
// While the divider runs, and while a last pixel waits for the previous result
// to be taken, nothing leaves the queue; pixels keep queueing until the queue
// is full, then in_stall rises and the front end holds. The user must write
// corner registers only while the block is idle; the block does not enforce it.
module quad_region_depth_average import qrda_pkg::*; #(
	parameter int MAX_COLUMNS   = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS      = MAX_ROWS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [CW-1:0]      cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PW-1:0]      pixel_col,
	input  logic [PW-1:0]      pixel_row,
	input  logic [31:0]        x_bits,
	input  logic [31:0]        y_bits,
	input  logic [31:0]        z_bits,
	input  logic               last_pixel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [NW-1:0]      points_found,
	output logic signed [31:0] mean_x,
	output logic signed [31:0] mean_y,
	output logic signed [31:0] mean_z,
	output logic               no_points
);
	logic signed [CW-1:0] ccol_q [4];
	logic signed [CW-1:0] crow_q [4];
	logic                 f_valid, q_room, q_ne, q_pop;
	qitem_t               f_item, q_head;

	// corner registers, even index is column, odd is row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				ccol_q[i] <= '0;
				crow_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index[0]) crow_q[cfg_index[2:1]] <= cfg_data;
			else              ccol_q[cfg_index[2:1]] <= cfg_data;
		end
	end

	// the front pipeline only moves when the queue can take a transfer
	assign in_stall = !q_room;

	qrda_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
		.clk, .arst_n, .in_valid, .advance(q_room), .ccol(ccol_q), .crow(crow_q),
		.pixel_col, .pixel_row, .x_bits, .y_bits, .z_bits, .last_pixel,
		.out_valid(f_valid), .out_item(f_item)
	);

	qrda_queue u_queue (
		.clk, .arst_n, .push(f_valid && q_room), .push_item(f_item), .pop(q_pop),
		.not_empty(q_ne), .room(q_room), .head(q_head)
	);

	qrda_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk, .arst_n, .has_item(q_ne), .item(q_head), .pop(q_pop),
		.res_valid(out_valid), .res_stall(out_stall), .points_found, .mean_x,
		.mean_y, .mean_z, .no_points
	);
endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the quad region depth average block
`timescale 1ns / 1ps

// Streams depth pixel frames through the block under several corner settings:
// a short directed table (empty frame, unit values, dropped points, tiny and
// saturated values, frame edge pixels), then random frames. Every transfer on
// the pixel side runs the local polygon/average predictor, and every result
// transfer is compared field by field with the oldest typed or predicted result.
module testbench;
	import qrda_pkg::*;

	// pixel as offered on the input channel
	typedef struct {
		bit [PW-1:0] col;
		bit [PW-1:0] row;
		bit [31:0]   fx;
		bit [31:0]   fy;
		bit [31:0]   fz;
		bit          last;
	} pixel_t;

	// one frame summary as seen on the output channel
	typedef struct {
		bit [NW-1:0] found;
		bit [31:0]   mx;
		bit [31:0]   my;
		bit [31:0]   mz;
		bit          empty;
	} frame_sum_t;

	// directed row: pixel plus a typed summary where one is obvious
	typedef struct {
		pixel_t     pix;
		bit         typed;
		frame_sum_t sum;
	} directed_row_t;

	localparam bit [31:0] F_ONE     = 32'h3F800000;
	localparam bit [31:0] F_TWO     = 32'h40000000;
	localparam bit [31:0] F_NEG_ONE = 32'hBF800000;
	localparam bit [31:0] F_NAN     = 32'h7FC00001;
	localparam bit [31:0] F_INF     = 32'h7F800000;
	localparam bit [31:0] F_NEG_ZER = 32'h80000000;
	localparam bit [31:0] F_TINY    = 32'h00000001;
	localparam bit [31:0] F_HUGE    = 32'h7F000000;
	localparam bit [31:0] F_NEG_HUG = 32'hFF000000;
	localparam int        DRAIN     = 100;
	localparam int        WATCHDOG  = 5000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [2:0]        cfg_index;
	logic [CW-1:0]     cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [PW-1:0]     pixel_col;
	logic [PW-1:0]     pixel_row;
	logic [31:0]       x_bits;
	logic [31:0]       y_bits;
	logic [31:0]       z_bits;
	logic              last_pixel;
	logic              out_valid;
	logic              out_stall;
	logic [NW-1:0]     points_found;
	logic signed [31:0] mean_x;
	logic signed [31:0] mean_y;
	logic signed [31:0] mean_z;
	logic              no_points;

	// predictor state
	longint     quad_col [CORNER_COUNT_DEF];
	longint     quad_row [CORNER_COUNT_DEF];
	longint     acc_x, acc_y, acc_z;
	int         acc_count;
	frame_sum_t pending_sums[$];

	int  errors;
	int  pixels_sent;
	int  frames_seen;
	int  burst_left;
	bit  long_hold_req;
	int  idle_cycles;

	quad_region_depth_average dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel_col(pixel_col), .pixel_row(pixel_row),
		.x_bits(x_bits), .y_bits(y_bits), .z_bits(z_bits), .last_pixel(last_pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.points_found(points_found), .mean_x(mean_x), .mean_y(mean_y),
		.mean_z(mean_z), .no_points(no_points)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// float bits to signed fixed point, truncated toward zero and saturated
	function automatic longint fixed_of(bit [31:0] f);
		longint unsigned sig;
		longint unsigned mag;
		int k;
		sig = {41'd0, f[22:0]};
		if (f[30:23] == 8'd0) begin
			k = -149 + FRACTION_BITS_DEF;
		end else begin
			sig[23] = 1'b1;
			k = int'(f[30:23]) - 150 + FRACTION_BITS_DEF;
		end
		if (k > 8) mag = 64'h80000000;
		else if (k >= 0) mag = sig << k;
		else if (k > -64) mag = sig >> (-k);
		else mag = 0;
		if (f[31]) begin
			if (mag > 64'h80000000) mag = 64'h80000000;
			return -longint'(mag);
		end
		if (mag > 64'h7FFFFFFF) mag = 64'h7FFFFFFF;
		return longint'(mag);
	endfunction

	// crossing-number test, edges from corner b to corner a in register order
	function automatic bit inside_quad(longint px, longint py);
		bit odd;
		int b;
		longint crossing;
		odd = 1'b0;
		b = CORNER_COUNT_DEF - 1;
		for (int a = 0; a < CORNER_COUNT_DEF; a++) begin
			if ((quad_row[a] > py) != (quad_row[b] > py)) begin
				crossing = (quad_col[b] - quad_col[a]) * (py - quad_row[a])
					/ (quad_row[b] - quad_row[a]) + quad_col[a];
				if (px < crossing) odd = !odd;
			end
			b = a;
		end
		return odd;
	endfunction

	// advance the predictor by one accepted pixel; returns whether a frame ended, with its summary in s
	function automatic bit predict_pixel(pixel_t p, output frame_sum_t s);
		bit bad, zero;
		bad = (p.fx[30:23] == 8'hFF) || (p.fy[30:23] == 8'hFF) || (p.fz[30:23] == 8'hFF);
		zero = (p.fx[30:0] == 0) && (p.fy[30:0] == 0) && (p.fz[30:0] == 0);
		s = '{default: 0};
		if (p.col < MAX_COLUMNS_DEF && p.row < MAX_ROWS_DEF && inside_quad(p.col, p.row)
				&& !bad && !zero && acc_count < int'(COUNT_LIMIT)) begin
			acc_x += fixed_of(p.fx);
			acc_y += fixed_of(p.fy);
			acc_z += fixed_of(p.fz);
			acc_count++;
		end
		if (!p.last) return 1'b0;
		if (acc_count == 0) begin
			s.empty = 1'b1;
		end else begin
			s.found = NW'(acc_count);
			s.mx = 32'(acc_x / acc_count);
			s.my = 32'(acc_y / acc_count);
			s.mz = 32'(acc_z / acc_count);
		end
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		acc_count = 0;
		return 1'b1;
	endfunction

	// write all eight corner registers back to back
	task automatic load_corners(input int c0, r0, c1, r1, c2, r2, c3, r3);
		int vals [8];
		vals = '{c0, r0, c1, r1, c2, r2, c3, r3};
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= CW'(vals[i]);
			if (i & 1) quad_row[i >> 1] = longint'($signed(CW'(vals[i])));
			else quad_col[i >> 1] = longint'($signed(CW'(vals[i])));
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one pixel, honoring bursts and gaps, and predict on the transfer
	task automatic send_pixel(input pixel_t p, input bit typed, input frame_sum_t typed_sum);
		frame_sum_t s;
		frame_sum_t want;
		if (burst_left == 0) begin
			int gap;
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		pixel_col <= p.col;
		pixel_row <= p.row;
		x_bits <= p.fx;
		y_bits <= p.fy;
		z_bits <= p.fz;
		last_pixel <= p.last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		pixels_sent++;
		if (predict_pixel(p, s)) begin
			want = typed ? typed_sum : s;
			pending_sums.insert(pending_sums.size(), want);
		end
	endtask

	// wait until every frame result is back and the pipeline has drained
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic bit [31:0] random_float();
		bit [31:0] f;
		f = $urandom();
		case ($urandom_range(0, 9))
			0: f[30:23] = 8'hFF;                           // nan or infinity
			1: f[30:0] = '0;                               // signed zero
			2: f[30:23] = 8'h00;                           // subnormal
			3: f[30:23] = 8'($urandom_range(150, 254));    // saturates
			4, 5: ;                                        // any pattern
			default: f[30:23] = 8'($urandom_range(110, 140));
		endcase
		return f;
	endfunction

	// random pixel mostly within the corner bounding box
	function automatic pixel_t random_pixel(bit last);
		pixel_t p;
		longint lo_c, hi_c, lo_r, hi_r;
		lo_c = quad_col[0]; hi_c = quad_col[0];
		lo_r = quad_row[0]; hi_r = quad_row[0];
		for (int i = 1; i < CORNER_COUNT_DEF; i++) begin
			if (quad_col[i] < lo_c) lo_c = quad_col[i];
			if (quad_col[i] > hi_c) hi_c = quad_col[i];
			if (quad_row[i] < lo_r) lo_r = quad_row[i];
			if (quad_row[i] > hi_r) hi_r = quad_row[i];
		end
		lo_c = lo_c < 0 ? 0 : lo_c;  hi_c = hi_c > 1023 ? 1023 : hi_c;
		lo_r = lo_r < 0 ? 0 : lo_r;  hi_r = hi_r > 1023 ? 1023 : hi_r;
		if ($urandom_range(0, 4) == 0 || lo_c > hi_c || lo_r > hi_r) begin
			p.col = PW'($urandom());
			p.row = PW'($urandom());
		end else begin
			p.col = PW'($urandom_range(int'(hi_c), int'(lo_c)));
			p.row = PW'($urandom_range(int'(hi_r), int'(lo_r)));
		end
		if ($urandom_range(0, 15) == 0) begin
			p.fx = $urandom_range(0, 1) ? 32'h0 : F_NEG_ZER;
			p.fy = '0;
			p.fz = F_NEG_ZER;
		end else begin
			p.fx = random_float();
			p.fy = random_float();
			p.fz = random_float();
		end
		p.last = last;
		return p;
	endfunction

	// receiver: stall pattern rotates through four modes, one long hold on request
	always @(posedge clk or negedge arst_n) begin : result_side
		int cyc;
		int hold;
		bit hold_used;
		if (!arst_n) begin
			out_stall <= 1'b0;
			cyc = 0;
			hold = 0;
			hold_used = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				frame_sum_t want;
				frames_seen++;
				if (pending_sums.size() == 0) begin
					$error("result transfer with no frame pending");
					errors++;
				end else begin
					want = pending_sums.pop_front();
					if (points_found !== want.found) begin
						$error("points_found exp %0d got %0d", want.found, points_found);
						errors++;
					end
					if (mean_x !== want.mx) begin
						$error("mean_x exp %h got %h", want.mx, mean_x);
						errors++;
					end
					if (mean_y !== want.my) begin
						$error("mean_y exp %h got %h", want.my, mean_y);
						errors++;
					end
					if (mean_z !== want.mz) begin
						$error("mean_z exp %h got %h", want.mz, mean_z);
						errors++;
					end
					if (no_points !== want.empty) begin
						$error("no_points exp %0d got %0d", want.empty, no_points);
						errors++;
					end
				end
			end
			cyc++;
			if (long_hold_req && !hold_used) begin
				hold = 600;
				hold_used = 1'b1;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				case ((cyc / 250) % 4)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= ((cyc % 7) < 3);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		directed_row_t empty_rows [3];
		directed_row_t square_rows [12];
		int corner_sets;
		errors = 0;
		pixels_sent = 0;
		frames_seen = 0;
		burst_left = 0;
		long_hold_req = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_C0_COL;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_col = '0;
		pixel_row = '0;
		x_bits = '0;
		y_bits = '0;
		z_bits = '0;
		last_pixel = 1'b0;
		for (int i = 0; i < CORNER_COUNT_DEF; i++) begin
			quad_col[i] = 0;
			quad_row[i] = 0;
		end
		acc_x = 0; acc_y = 0; acc_z = 0; acc_count = 0;

		// reset corners are all zero, so no pixel is inside: empty frames
		empty_rows[0] = '{'{0, 0, F_ONE, F_ONE, F_ONE, 0}, 0, '{default: 0}};
		empty_rows[1] = '{'{1023, 1023, F_TWO, F_ONE, F_ONE, 1}, 1, '{0, 0, 0, 0, 1}};
		empty_rows[2] = '{'{5, 7, F_ONE, F_ONE, F_ONE, 1}, 1, '{0, 0, 0, 0, 1}};
		// widest square covers every pixel; two of its edges are horizontal
		square_rows[0] = '{'{0, 0, F_ONE, F_TWO, F_NEG_ONE, 1}, 1,
			'{1, 32'h10000, 32'h20000, 32'hFFFF0000, 0}};
		square_rows[1] = '{'{10, 10, F_NAN, F_ONE, F_ONE, 0}, 0, '{default: 0}};
		square_rows[2] = '{'{11, 10, F_ONE, F_INF, F_ONE, 0}, 0, '{default: 0}};
		square_rows[3] = '{'{12, 10, F_NEG_ZER, 0, F_NEG_ZER, 0}, 0, '{default: 0}};
		square_rows[4] = '{'{13, 10, F_TINY, 0, 0, 1}, 1, '{1, 0, 0, 0, 0}};
		square_rows[5] = '{'{1023, 1023, F_HUGE, F_NEG_HUG, 0, 1}, 1,
			'{1, 32'h7FFFFFFF, 32'h80000000, 0, 0}};
		square_rows[6] = '{'{1023, 0, F_ONE, F_ONE, F_ONE, 0}, 0, '{default: 0}};
		square_rows[7] = '{'{0, 1023, F_NEG_ONE, F_TWO, F_TINY, 0}, 0, '{default: 0}};
		square_rows[8] = '{'{512, 512, 32'hFFFFFFFF, F_ONE, F_ONE, 0}, 0, '{default: 0}};
		square_rows[9] = '{'{341, 682, 32'h3EAAAAAB, 32'hC0490FDB, F_TWO, 1}, 0,
			'{default: 0}};
		square_rows[10] = '{'{600, 300, F_ONE, F_ONE, F_ONE, 0}, 0, '{default: 0}};
		square_rows[11] = '{'{0, 0, F_NEG_ZER, F_NEG_ZER, F_NEG_ZER, 1}, 0, '{default: 0}};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (empty_rows[i]) send_pixel(empty_rows[i].pix, empty_rows[i].typed,
			empty_rows[i].sum);
		settle();
		load_corners(-4096, -4096, 4095, -4096, 4095, 4095, -4096, 4095);
		foreach (square_rows[i]) send_pixel(square_rows[i].pix, square_rows[i].typed,
			square_rows[i].sum);
		settle();

		// random frames under a series of corner settings
		corner_sets = 6;
		for (int phase = 0; phase < corner_sets; phase++) begin
			int sent_here;
			case (phase)
				0: load_corners(4095, 4095, 4095, 4095, -4096, -4096, -4096, -4096);
				1: load_corners(-4096, -4096, 4095, -4096, 4095, 4095, -4096, 4095);
				default: begin
					int cc [8];
					foreach (cc[i]) cc[i] = ($urandom_range(0, 5) == 0) ?
						$urandom_range(0, 8191) - 4096 : $urandom_range(0, 1100) - 40;
					load_corners(cc[0], cc[1], cc[2], cc[3], cc[4], cc[5], cc[6], cc[7]);
				end
			endcase
			sent_here = 0;
			while (sent_here < 230) begin
				int frame_len;
				frame_len = $urandom_range(1, 24);
				if (phase == 3 && sent_here >= 60) long_hold_req = 1'b1;
				for (int k = 0; k < frame_len; k++)
					send_pixel(random_pixel(k == frame_len - 1), 1'b0, '{default: 0});
				long_hold_req = 1'b0;
				sent_here += frame_len;
			end
			settle();
		end

		$display("run covered %0d pixel transfers and %0d frame results", pixels_sent,
			frames_seen);
		$display("corner settings: reset, full square, degenerate, %0d random",
			corner_sets - 2);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

// ===== quad_region_depth_average.f =====
rtl/qrda_pkg.sv
rtl/qrda_front.sv
rtl/qrda_queue.sv
rtl/qrda_back.sv
rtl/quad_region_depth_average.sv
tb/testbench.sv
